// ===== design/nmc_pkg.sv =====
package nmc_pkg;

    localparam int unsigned LEN_W = 17;

    localparam logic [3:0] CONT_MARK  = 4'hF;
    localparam logic [3:0] FREE_ENTRY = 4'h0;

    localparam logic [2:0] CMD_FREE     = 3'd0;
    localparam logic [2:0] CMD_FREE_ALL = 3'd1;
    localparam logic [2:0] CMD_SIZE     = 3'd2;
    localparam logic [2:0] CMD_FIRST    = 3'd3;
    localparam logic [2:0] CMD_OWNER    = 3'd4;
    localparam logic [2:0] CMD_WRITE    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [1:0] ST_NOT_OWNER = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    localparam logic REG_USE_BASE   = 1'b0;
    localparam logic REG_USE_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIRST,
        S_BACK,
        S_FWD,
        S_ALL,
        S_DONE
    } t_state;

endpackage

// ===== design/nmc_req_if.sv =====
interface nmc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] address;
    logic [3:0]  process_id;
    logic [3:0]  entry_value;

    modport source (output valid, command, address, process_id, entry_value, input ready);
    modport sink (input valid, command, address, process_id, entry_value, output ready);
endinterface

// ===== design/nmc_rsp_if.sv =====
interface nmc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic [1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

// ===== design/nibble_map_chunk_manager.sv =====
// after reset a clearing pass writes every map entry to free, no requests taken
// write_entry, out-of-area requests and unused commands go straight from accept to the done state
// free, size, first byte, owner: walk back to the chunk start, free and size then walk forward
// over the chunk; free_all walks min(use_length, USE_BYTES) entries, one map entry per cycle
// the pace of each walk is set by the single read port of the map ram, one entry read per cycle
// a finished result waits in an output register; the next request is taken meanwhile
module nibble_map_chunk_manager
    import nmc_pkg::*;
#(
    parameter int unsigned USE_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nmc_req_if.sink           i_req,
    nmc_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    localparam int unsigned AW = $clog2(USE_BYTES);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [2:0]         r_cmd, n_cmd;
    logic [3:0]         r_pid, n_pid;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_in_run, n_in_run;
    logic               r_match, n_match;
    logic [15:0]        r_rval, n_rval;
    logic [1:0]         r_rst, n_rst;
    logic [15:0]        r_use_base;
    logic [10:0]        r_use_length;
    logic               r_out_valid;
    logic [15:0]        r_out_value;
    logic [1:0]         r_out_status;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [3:0]         ram_wdata;
    logic [3:0]         rd;

    logic [LEN_W-1:0]   area_len;
    logic [15:0]        offset;
    logic               in_area;
    logic               ptr_more;
    logic               start_hit;
    logic [3:0]         run_owner;
    logic               out_free;

    nmc_ram #(.WIDTH(4), .DEPTH(USE_BYTES)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_ptr),
        .o_rdata (rd)
    );

    assign area_len = ({6'b0, r_use_length} > LEN_W'(USE_BYTES)) ?
                      LEN_W'(USE_BYTES) : {6'b0, r_use_length};
    assign offset   = i_req.address - r_use_base;
    assign in_area  = (i_req.address >= r_use_base) && ({1'b0, offset} < area_len);
    assign ptr_more = ({{(LEN_W-AW){1'b0}}, r_ptr} + LEN_W'(1)) < area_len;
    assign out_free = !r_out_valid || o_rsp.ready;
    // a run of continuation marks with nothing before it belongs to owner 15 at the map start,
    // after a free entry the chunk starts at that free entry
    assign run_owner = (rd == CONT_MARK) ? ((r_ptr == '0) ? CONT_MARK : FREE_ENTRY) : rd;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cmd     = r_cmd;
        n_pid     = r_pid;
        n_cnt     = r_cnt;
        n_in_run  = r_in_run;
        n_match   = r_match;
        n_rval    = r_rval;
        n_rst     = r_rst;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = FREE_ENTRY;
        start_hit = 1'b0;
        i_req.ready = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_ptr == AW'(USE_BYTES - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_cmd  = i_req.command;
                    n_pid  = i_req.process_id;
                    n_rval = '0;
                    n_rst  = ST_OK;
                    if (i_req.command == CMD_FREE_ALL) begin
                        if (area_len == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_ptr    = '0;
                            n_in_run = 1'b0;
                            n_match  = 1'b0;
                            n_state  = S_ALL;
                        end
                    end else if (i_req.command > CMD_WRITE) begin
                        n_state = S_DONE;
                    end else if (!in_area) begin
                        n_rst   = ST_OUTSIDE;
                        n_state = S_DONE;
                    end else if (i_req.command == CMD_WRITE) begin
                        ram_we    = 1'b1;
                        ram_waddr = offset[AW-1:0];
                        ram_wdata = i_req.entry_value;
                        n_state   = S_DONE;
                    end else begin
                        n_ptr   = offset[AW-1:0];
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                if (rd == FREE_ENTRY) begin
                    n_rst   = ST_NOT_ALLOC;
                    n_state = S_DONE;
                end else if (rd == CONT_MARK && r_ptr != '0) begin
                    n_ptr   = r_ptr - AW'(1);
                    n_state = S_BACK;
                end else begin
                    start_hit = 1'b1;
                end
            end
            S_BACK: begin
                if (rd == CONT_MARK && r_ptr != '0) begin
                    n_ptr = r_ptr - AW'(1);
                end else begin
                    start_hit = 1'b1;
                end
            end
            S_FWD: begin
                if (rd == CONT_MARK) begin
                    ram_we = (r_cmd == CMD_FREE);
                    n_cnt  = r_cnt + LEN_W'(1);
                end
                if (rd == CONT_MARK && ptr_more) begin
                    n_ptr = r_ptr + AW'(1);
                end else begin
                    n_rval  = (r_cmd == CMD_SIZE) ? n_cnt[15:0] : 16'd0;
                    n_state = S_DONE;
                end
            end
            S_ALL: begin
                if (rd == CONT_MARK && r_in_run) begin
                    ram_we = r_match;
                end else begin
                    n_in_run = (rd != FREE_ENTRY);
                    n_match  = (run_owner == r_pid);
                    ram_we   = (run_owner == r_pid) && (rd != FREE_ENTRY);
                end
                if (ptr_more) begin
                    n_ptr = r_ptr + AW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // chunk start found at r_ptr, its entry is the owner
        if (start_hit) begin
            case (r_cmd)
                CMD_OWNER: begin
                    n_rval  = {12'b0, rd};
                    n_state = S_DONE;
                end
                CMD_FIRST: begin
                    n_rval  = r_use_base + 16'(r_ptr);
                    n_state = S_DONE;
                end
                CMD_FREE, CMD_SIZE: begin
                    if (r_cmd == CMD_FREE && rd != r_pid) begin
                        n_rst   = ST_NOT_OWNER;
                        n_state = S_DONE;
                    end else begin
                        ram_we = (r_cmd == CMD_FREE);
                        n_cnt  = LEN_W'(1);
                        if (ptr_more) begin
                            n_ptr   = r_ptr + AW'(1);
                            n_state = S_FWD;
                        end else begin
                            n_rval  = (r_cmd == CMD_SIZE) ? 16'd1 : 16'd0;
                            n_state = S_DONE;
                        end
                    end
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
        r_cmd    <= n_cmd;
        r_pid    <= n_pid;
        r_cnt    <= n_cnt;
        r_in_run <= n_in_run;
        r_match  <= n_match;
        r_rval   <= n_rval;
        r_rst    <= n_rst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_base   <= 16'd0;
            r_use_length <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_USE_BASE:   r_use_base   <= i_cfg_data;
                REG_USE_LENGTH: r_use_length <= i_cfg_data[10:0];
                default:        r_use_base   <= r_use_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_value  <= r_rval;
            r_out_status <= r_rst;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.status = r_out_status;
endmodule

// ===== design/nmc_ram.sv =====
module nmc_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
